/* rtl/core/hrwv_pkg.sv */
// ----------------------------------------------------------------------------
// hrwv_pkg
// Shared types and constants for the holding register write validator:
// register addresses, magic words, status codes and state records.
// ----------------------------------------------------------------------------
package hrwv_pkg;

   // register addresses inside the writable table
   localparam logic [15:0] ADDR_CLEAR     = 16'd0;
   localparam logic [15:0] ADDR_SPEED     = 16'd1;
   localparam logic [15:0] ADDR_PARITY    = 16'd2;
   localparam logic [15:0] ADDR_ID        = 16'd3;
   localparam logic [15:0] ADDR_TERM      = 16'd4;
   localparam logic [15:0] ADDR_SAVE      = 16'd5;
   localparam logic [15:0] ADDR_RESTORE   = 16'd6;
   localparam logic [15:0] ADDR_CONTROL   = 16'd7;
   localparam logic [15:0] ADDR_SERIAL_LO = 16'd8;
   localparam logic [15:0] ADDR_SERIAL_HI = 16'd9;
   localparam logic [15:0] ADDR_CALIB     = 16'd10;

   // magic words
   localparam logic [15:0] CLEAR_MAGIC  = 16'h00FF;
   localparam logic [15:0] SAVE_MAGIC   = 16'h6173;
   localparam logic [15:0] LOAD_MAGIC   = 16'h6F6C;
   localparam logic [15:0] RESET_MAGIC  = 16'h5330;
   localparam logic [15:0] UNLOCK_MAGIC = 16'h0020;
   localparam logic [15:0] LOCK_MAGIC   = 16'h0010;

   // termination accepted range
   localparam logic [15:0] TERM_LOW  = 16'd1;
   localparam logic [15:0] TERM_HIGH = 16'd2;

   // request status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_REG    = 2'd1;
   localparam logic [1:0] STATUS_BAD_VALUE = 2'd2;

   // csr indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_MIN  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_MAX  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARITY_MIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARITY_MAX = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ID_MIN     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ID_MAX     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_CALIB_MIN  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_CALIB_MAX  = 3'd7;

   // one word of a write request
   typedef struct packed {
      logic        first_word;
      logic        last_word;
      logic [15:0] reg_address;
      logic [16:0] request_end;
      logic [15:0] word_value;
   } hrwv_word_type;

   // range limits from the csr bank
   typedef struct packed {
      logic [15:0] speed_min;
      logic [15:0] speed_max;
      logic [15:0] parity_min;
      logic [15:0] parity_max;
      logic [15:0] id_min;
      logic [15:0] id_max;
      logic [15:0] calib_min;
      logic [15:0] calib_max;
   } hrwv_limits_type;

   // stored settings and running request status
   typedef struct packed {
      logic        unlocked;
      logic [1:0]  request_error;
      logic [15:0] speed;
      logic [15:0] parity;
      logic [15:0] id;
      logic [15:0] term;
      logic [15:0] serial_lo;
      logic [15:0] serial_hi;
      logic [15:0] calib;
   } hrwv_state_type;

   // command pulses
   typedef struct packed {
      logic clear_counters;
      logic save_request;
      logic restore_request;
      logic soft_reset;
   } hrwv_pulse_type;

endpackage

/* rtl/core/hrwv_decode.sv */
// ----------------------------------------------------------------------------
// hrwv_decode
// Decodes one request word against the stored settings: table bound check,
// per-register range checks, magic words and the unlock gate.
// ----------------------------------------------------------------------------
module hrwv_decode #(
   parameter int unsigned TABLE_SIZE = 13
) (
   input  hrwv_pkg::hrwv_word_type   word,
   input  hrwv_pkg::hrwv_limits_type limits,
   input  hrwv_pkg::hrwv_state_type  state_cur,
   output hrwv_pkg::hrwv_state_type  state_next,
   output hrwv_pkg::hrwv_pulse_type  pulses
);
   import hrwv_pkg::*;

   localparam logic [16:0] TABLE_END  = 17'(TABLE_SIZE);
   localparam logic [15:0] TABLE_ADDR = 16'(TABLE_SIZE);

   logic [1:0]  err_base;
   logic        out_of_table;
   logic        value_bad;
   logic [15:0] val;

   // bound check and error base for this word
   assign val          = word.word_value;
   assign err_base     = word.first_word ? STATUS_OK : state_cur.request_error;
   assign out_of_table = (word.request_end > TABLE_END) || (word.reg_address >= TABLE_ADDR);

   // register decode
   always_comb begin
      state_next = state_cur;
      pulses     = '0;
      value_bad  = 1'b0;
      if (!out_of_table) begin
         unique case (word.reg_address)
            ADDR_CLEAR: begin
               pulses.clear_counters = (val == CLEAR_MAGIC);
            end
            ADDR_SPEED: begin
               if (val >= limits.speed_min && val <= limits.speed_max) state_next.speed = val;
               else value_bad = 1'b1;
            end
            ADDR_PARITY: begin
               if (val >= limits.parity_min && val <= limits.parity_max) state_next.parity = val;
               else value_bad = 1'b1;
            end
            ADDR_ID: begin
               if (val >= limits.id_min && val <= limits.id_max) state_next.id = val;
               else value_bad = 1'b1;
            end
            ADDR_TERM: begin
               if (val >= TERM_LOW && val <= TERM_HIGH) state_next.term = val;
               else value_bad = 1'b1;
            end
            ADDR_SAVE: begin
               pulses.save_request = (val == SAVE_MAGIC);
            end
            ADDR_RESTORE: begin
               pulses.restore_request = (val == LOAD_MAGIC);
            end
            ADDR_CONTROL: begin
               pulses.soft_reset = (val == RESET_MAGIC);
               if (val == UNLOCK_MAGIC) state_next.unlocked = 1'b1;
               if (val == LOCK_MAGIC) state_next.unlocked = 1'b0;
            end
            ADDR_SERIAL_LO: begin
               if (state_cur.unlocked) state_next.serial_lo = val;
               else value_bad = 1'b1;
            end
            ADDR_SERIAL_HI: begin
               if (state_cur.unlocked) state_next.serial_hi = val;
               else value_bad = 1'b1;
            end
            ADDR_CALIB: begin
               if (state_cur.unlocked && val >= limits.calib_min && val <= limits.calib_max)
                  state_next.calib = val;
               else value_bad = 1'b1;
            end
            default: begin
               // unused addresses inside the table are accepted silently
            end
         endcase
      end

      // sticky request status
      if (out_of_table) state_next.request_error = STATUS_NO_REG;
      else if (value_bad && err_base == STATUS_OK) state_next.request_error = STATUS_BAD_VALUE;
      else state_next.request_error = err_base;
   end

endmodule

/* rtl/core/holding_register_write_validator.sv */
// ----------------------------------------------------------------------------
// holding_register_write_validator
// Validates and applies the words of a multi-register holding register write.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one request word per transaction (valid/stall). first_word opens
//            a request and clears its status, last_word closes it.
//   rsp_*  : one result per word: running status, command pulses, snapshot of
//            all stored settings, done_res copies last_word.
//   csr_*  : range limits, written by index while the block is idle;
//            csr_ready is always high.
// Pipeline: a word is registered on input, decoded combinationally from the
//   input register and its result is registered, which raises rsp_valid.
// Throughput: one word per cycle unless a stalled result holds it, set by the
//   single decode stage between the input register and the result register.
// Stall: when rsp_stall holds a pending result, the input register keeps its
//   word and req_stall goes high only once both stages are full.
// Reset: synchronous, active high; clears both stages, the settings, the
//   lock (locked) and the status, and loads the default range limits.
// ----------------------------------------------------------------------------
module holding_register_write_validator #(
   parameter int unsigned TABLE_SIZE = 13
) (
   input  logic                              clock,
   input  logic                              reset,
   // request words
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_first_word,
   input  logic                              req_last_word,
   input  logic [15:0]                       req_reg_address,
   input  logic [16:0]                       req_request_end,
   input  logic [15:0]                       req_word_value,
   // results
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_clear_counters,
   output logic                              rsp_save_request,
   output logic                              rsp_restore_request,
   output logic                              rsp_soft_reset,
   output logic [15:0]                       rsp_bus_speed,
   output logic [15:0]                       rsp_bus_parity,
   output logic [15:0]                       rsp_slave_id,
   output logic [15:0]                       rsp_termination,
   output logic [31:0]                       rsp_serial_number,
   output logic [15:0]                       rsp_calibration,
   output logic                              rsp_done_res,
   // configuration
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hrwv_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [15:0]                       csr_data
);
   import hrwv_pkg::*;

   hrwv_limits_type limits_ff;
   hrwv_state_type  state_ff;
   hrwv_state_type  state_in;
   hrwv_pulse_type  pulses;
   hrwv_word_type   word_ff;
   logic            word_valid_ff;
   logic            advance;
   logic            rsp_valid_ff;
   hrwv_state_type  rsp_state_ff;
   hrwv_pulse_type  rsp_pulses_ff;
   logic            rsp_last_ff;

   // handshake
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = word_valid_ff && !advance;
   assign csr_ready = 1'b1;

   // csr bank
   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.speed_min  <= 16'd0;
         limits_ff.speed_max  <= 16'd7;
         limits_ff.parity_min <= 16'd0;
         limits_ff.parity_max <= 16'd2;
         limits_ff.id_min     <= 16'd1;
         limits_ff.id_max     <= 16'd247;
         limits_ff.calib_min  <= 16'd0;
         limits_ff.calib_max  <= 16'hFFFF;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SPEED_MIN:  limits_ff.speed_min  <= csr_data;
            CSR_SPEED_MAX:  limits_ff.speed_max  <= csr_data;
            CSR_PARITY_MIN: limits_ff.parity_min <= csr_data;
            CSR_PARITY_MAX: limits_ff.parity_max <= csr_data;
            CSR_ID_MIN:     limits_ff.id_min     <= csr_data;
            CSR_ID_MAX:     limits_ff.id_max     <= csr_data;
            CSR_CALIB_MIN:  limits_ff.calib_min  <= csr_data;
            CSR_CALIB_MAX:  limits_ff.calib_max  <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         word_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         word_ff.first_word  <= req_first_word;
         word_ff.last_word   <= req_last_word;
         word_ff.reg_address <= req_reg_address;
         word_ff.request_end <= req_request_end;
         word_ff.word_value  <= req_word_value;
      end
   end

   // word decode
   hrwv_decode #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_decode (
      .word       (word_ff),
      .limits     (limits_ff),
      .state_cur  (state_ff),
      .state_next (state_in),
      .pulses     (pulses)
   );

   // settings and status
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (word_valid_ff && advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= word_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (word_valid_ff && advance) begin
         rsp_state_ff  <= state_in;
         rsp_pulses_ff <= pulses;
         rsp_last_ff   <= word_ff.last_word;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_state_ff.request_error;
   assign rsp_clear_counters  = rsp_pulses_ff.clear_counters;
   assign rsp_save_request    = rsp_pulses_ff.save_request;
   assign rsp_restore_request = rsp_pulses_ff.restore_request;
   assign rsp_soft_reset      = rsp_pulses_ff.soft_reset;
   assign rsp_bus_speed       = rsp_state_ff.speed;
   assign rsp_bus_parity      = rsp_state_ff.parity;
   assign rsp_slave_id        = rsp_state_ff.id;
   assign rsp_termination     = rsp_state_ff.term;
   assign rsp_serial_number   = {rsp_state_ff.serial_hi, rsp_state_ff.serial_lo};
   assign rsp_calibration     = rsp_state_ff.calib;
   assign rsp_done_res        = rsp_last_ff;

`ifndef SYNTHESIS
   // a single word raises at most one command pulse
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_clear_counters, rsp_save_request,
                              rsp_restore_request, rsp_soft_reset}))
      else $error("more than one command pulse in a result");

   // the status never takes the unused code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_NO_REG ||
                     rsp_status == STATUS_BAD_VALUE))
      else $error("result status out of range");

   // stored termination only ever holds TERM_LOW to TERM_HIGH or its reset value
   assert property (@(posedge clock) disable iff (reset)
      state_ff.term <= TERM_HIGH)
      else $error("termination setting out of range");

   // input is only held back while a result waits and both stages are full
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && word_valid_ff))
      else $error("input stalled without a blocked result");

   // a held result keeps its status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)))
      else $error("stalled result changed");
`endif

endmodule

/* tb/tb_holding_register_write_validator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_holding_register_write_validator
// Self-checking bench for the holding register write validator. A driver
// feeds request words from a queue with random gaps. A shadow of the settings,
// lock and request status predicts every result. A monitor stalls the result
// side at random and checks each result field by field against the oldest
// prediction. The range limits are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb_holding_register_write_validator;
   import hrwv_pkg::*;

   localparam int unsigned TABLE_SIZE     = 13;
   localparam logic [16:0] TABLE_END      = 17'(TABLE_SIZE);
   localparam int          SETTLE_CYCLES  = 4;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          PHASE_WORDS    = 280;
   localparam int          PRINT_LIMIT    = 40;

   // predicted result of one request word
   typedef struct packed {
      logic [1:0]  status;
      logic        clear_counters;
      logic        save_request;
      logic        restore_request;
      logic        soft_reset;
      logic [15:0] bus_speed;
      logic [15:0] bus_parity;
      logic [15:0] slave_id;
      logic [15:0] termination;
      logic [31:0] serial_number;
      logic [15:0] calibration;
      logic        done_res;
   } word_outcome_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_first_word = 1'b0;
   logic                   req_last_word = 1'b0;
   logic [15:0]            req_reg_address = '0;
   logic [16:0]            req_request_end = '0;
   logic [15:0]            req_word_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_status;
   logic                   rsp_clear_counters;
   logic                   rsp_save_request;
   logic                   rsp_restore_request;
   logic                   rsp_soft_reset;
   logic [15:0]            rsp_bus_speed;
   logic [15:0]            rsp_bus_parity;
   logic [15:0]            rsp_slave_id;
   logic [15:0]            rsp_termination;
   logic [31:0]            rsp_serial_number;
   logic [15:0]            rsp_calibration;
   logic                   rsp_done_res;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [15:0]            csr_data = '0;

   // shadow of the block
   hrwv_state_type  settings;
   hrwv_limits_type limits;

   hrwv_word_type    pending_words[$];
   word_outcome_type expected_outcomes[$];
   hrwv_word_type    driven_word;
   int               words_queued = 0;
   int               results_seen = 0;
   int               mismatch_count = 0;
   int               send_gap = 0;
   int               stall_left = 0;
   int               quiet_cycles = 0;
   bit               req_idle_on = 1'b1;
   bit               rsp_idle_on = 1'b1;

   holding_register_write_validator #(
      .TABLE_SIZE (TABLE_SIZE)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_first_word      (req_first_word),
      .req_last_word       (req_last_word),
      .req_reg_address     (req_reg_address),
      .req_request_end     (req_request_end),
      .req_word_value      (req_word_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_clear_counters  (rsp_clear_counters),
      .rsp_save_request    (rsp_save_request),
      .rsp_restore_request (rsp_restore_request),
      .rsp_soft_reset      (rsp_soft_reset),
      .rsp_bus_speed       (rsp_bus_speed),
      .rsp_bus_parity      (rsp_bus_parity),
      .rsp_slave_id        (rsp_slave_id),
      .rsp_termination     (rsp_termination),
      .rsp_serial_number   (rsp_serial_number),
      .rsp_calibration     (rsp_calibration),
      .rsp_done_res        (rsp_done_res),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // write validation shadow
   // ------------------------------------------------------------------------
   function automatic hrwv_limits_type default_limits();
      hrwv_limits_type l;
      l.speed_min  = 16'd0;
      l.speed_max  = 16'd7;
      l.parity_min = 16'd0;
      l.parity_max = 16'd2;
      l.id_min     = 16'd1;
      l.id_max     = 16'd247;
      l.calib_min  = 16'd0;
      l.calib_max  = 16'hFFFF;
      return l;
   endfunction

   function automatic bit in_bounds(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
      return (v >= lo) && (v <= hi);
   endfunction

   // a value error never overrides an earlier error of the same request
   function automatic void flag_bad_value();
      if (settings.request_error == STATUS_OK) settings.request_error = STATUS_BAD_VALUE;
   endfunction

   function automatic word_outcome_type apply_word(hrwv_word_type w);
      word_outcome_type o;
      logic [15:0]      v;
      o = '0;
      v = w.word_value;
      if (w.first_word) settings.request_error = STATUS_OK;
      if (w.request_end > TABLE_SIZE || w.reg_address >= TABLE_SIZE) begin
         settings.request_error = STATUS_NO_REG;
      end else begin
         case (w.reg_address)
            ADDR_CLEAR: o.clear_counters = (v == CLEAR_MAGIC);
            ADDR_SPEED: begin
               if (in_bounds(v, limits.speed_min, limits.speed_max)) settings.speed = v;
               else flag_bad_value();
            end
            ADDR_PARITY: begin
               if (in_bounds(v, limits.parity_min, limits.parity_max)) settings.parity = v;
               else flag_bad_value();
            end
            ADDR_ID: begin
               if (in_bounds(v, limits.id_min, limits.id_max)) settings.id = v;
               else flag_bad_value();
            end
            ADDR_TERM: begin
               if (in_bounds(v, TERM_LOW, TERM_HIGH)) settings.term = v;
               else flag_bad_value();
            end
            ADDR_SAVE:    o.save_request = (v == SAVE_MAGIC);
            ADDR_RESTORE: o.restore_request = (v == LOAD_MAGIC);
            ADDR_CONTROL: begin
               o.soft_reset = (v == RESET_MAGIC);
               if (v == UNLOCK_MAGIC) settings.unlocked = 1'b1;
               if (v == LOCK_MAGIC) settings.unlocked = 1'b0;
            end
            ADDR_SERIAL_LO: begin
               if (settings.unlocked) settings.serial_lo = v;
               else flag_bad_value();
            end
            ADDR_SERIAL_HI: begin
               if (settings.unlocked) settings.serial_hi = v;
               else flag_bad_value();
            end
            ADDR_CALIB: begin
               if (in_bounds(v, limits.calib_min, limits.calib_max) && settings.unlocked)
                  settings.calib = v;
               else flag_bad_value();
            end
            default: ;
         endcase
      end
      o.status        = settings.request_error;
      o.bus_speed     = settings.speed;
      o.bus_parity    = settings.parity;
      o.slave_id      = settings.id;
      o.termination   = settings.term;
      o.serial_number = {settings.serial_hi, settings.serial_lo};
      o.calibration   = settings.calib;
      o.done_res      = w.last_word;
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // mismatch reporting
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("ERROR %0t result %0d %s: got %0h want %0h", $time, results_seen, what,
                  got, want);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   task automatic check_outcome();
      word_outcome_type want;
      if (expected_outcomes.size() == 0) begin
         report_mismatch("result with nothing expected", {30'd0, rsp_status}, '0);
      end else begin
         want = expected_outcomes.pop_front();
         check_field("status", 32'(rsp_status), 32'(want.status));
         check_field("clear_counters", 32'(rsp_clear_counters), 32'(want.clear_counters));
         check_field("save_request", 32'(rsp_save_request), 32'(want.save_request));
         check_field("restore_request", 32'(rsp_restore_request),
                     32'(want.restore_request));
         check_field("soft_reset", 32'(rsp_soft_reset), 32'(want.soft_reset));
         check_field("bus_speed", 32'(rsp_bus_speed), 32'(want.bus_speed));
         check_field("bus_parity", 32'(rsp_bus_parity), 32'(want.bus_parity));
         check_field("slave_id", 32'(rsp_slave_id), 32'(want.slave_id));
         check_field("termination", 32'(rsp_termination), 32'(want.termination));
         check_field("serial_number", rsp_serial_number, want.serial_number);
         check_field("calibration", 32'(rsp_calibration), 32'(want.calibration));
         check_field("done_res", 32'(rsp_done_res), 32'(want.done_res));
      end
      results_seen++;
   endtask

   // ------------------------------------------------------------------------
   // idle lengths: mostly short, a few long
   // ------------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // request word driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) expected_outcomes.push_back(apply_word(driven_word));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               driven_word = pending_words.pop_front();
               req_first_word  <= driven_word.first_word;
               req_last_word   <= driven_word.last_word;
               req_reg_address <= driven_word.reg_address;
               req_request_end <= driven_word.request_end;
               req_word_value  <= driven_word.word_value;
               req_valid       <= 1'b1;
               send_gap = req_idle_on ? pick_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_outcome();
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic add_word(input bit first_w, input bit last_w, input logic [15:0] addr,
                           input logic [16:0] rend, input logic [15:0] val);
      hrwv_word_type w;
      w.first_word  = first_w;
      w.last_word   = last_w;
      w.reg_address = addr;
      w.request_end = rend;
      w.word_value  = val;
      pending_words.push_back(w);
      words_queued++;
   endtask

   // values biased toward magic words and range edges of the target register
   function automatic logic [15:0] pick_value(logic [15:0] addr);
      logic [15:0] lo;
      logic [15:0] hi;
      int          r;
      r = $urandom_range(0, 9);
      if (r >= 7) return 16'($urandom);
      case (addr)
         ADDR_CLEAR:   return CLEAR_MAGIC;
         ADDR_SAVE:    return SAVE_MAGIC;
         ADDR_RESTORE: return LOAD_MAGIC;
         ADDR_CONTROL: begin
            case ($urandom_range(0, 2))
               0:       return RESET_MAGIC;
               1:       return UNLOCK_MAGIC;
               default: return LOCK_MAGIC;
            endcase
         end
         ADDR_SPEED:  begin lo = limits.speed_min;  hi = limits.speed_max;  end
         ADDR_PARITY: begin lo = limits.parity_min; hi = limits.parity_max; end
         ADDR_ID:     begin lo = limits.id_min;     hi = limits.id_max;     end
         ADDR_TERM:   begin lo = TERM_LOW;          hi = TERM_HIGH;         end
         ADDR_CALIB:  begin lo = limits.calib_min;  hi = limits.calib_max;  end
         default:     return 16'($urandom);
      endcase
      if (r < 4 && lo <= hi) return lo + 16'($urandom_range(0, hi - lo));
      case ($urandom_range(0, 3))
         0:       return lo;
         1:       return hi;
         2:       return lo - 16'd1;
         default: return hi + 16'd1;
      endcase
   endfunction

   task automatic add_request(input int start, input int count, input int rend);
      for (int i = 0; i < count; i++)
         add_word(i == 0, i == count - 1, 16'(start + i), 17'(rend),
                  pick_value(16'(start + i)));
   endtask

   task automatic add_noise_word();
      add_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, TABLE_SIZE + 2)),
               $urandom_range(0, 1) ? 17'($urandom_range(0, 131070))
                                    : 17'($urandom_range(0, TABLE_SIZE + 1)),
               16'($urandom));
   endtask

   // block until every queued word has been answered, then let it settle
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_outcomes.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SPEED_MIN:  limits.speed_min  = data;
         CSR_SPEED_MAX:  limits.speed_max  = data;
         CSR_PARITY_MIN: limits.parity_min = data;
         CSR_PARITY_MAX: limits.parity_max = data;
         CSR_ID_MIN:     limits.id_min     = data;
         CSR_ID_MAX:     limits.id_max     = data;
         CSR_CALIB_MIN:  limits.calib_min  = data;
         CSR_CALIB_MAX:  limits.calib_max  = data;
         default: ;
      endcase
   endtask

   function automatic hrwv_limits_type random_limits();
      hrwv_limits_type l;
      l.speed_min  = 16'($urandom_range(0, 20));
      l.speed_max  = l.speed_min + 16'($urandom_range(0, 10));
      l.parity_min = 16'($urandom_range(0, 5));
      l.parity_max = l.parity_min + 16'($urandom_range(0, 4));
      l.id_min     = 16'($urandom_range(0, 300));
      l.id_max     = l.id_min + 16'($urandom_range(0, 100));
      l.calib_min  = 16'($urandom);
      l.calib_max  = l.calib_min + 16'($urandom_range(0, 16'h4000));
      return l;
   endfunction

   // mostly well-formed requests, some running past the table, some noise
   task automatic add_random_traffic(input int n_words);
      int base;
      int start;
      int count;
      int r;
      bit drained;
      base = words_queued;
      drained = 1'b0;
      while (words_queued - base < n_words) begin
         // hold the sender once until every result is back
         if (!drained && words_queued - base >= n_words / 2) begin
            wait_idle();
            drained = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 78) begin
            start = ($urandom_range(0, 3) == 0) ? int'(ADDR_CONTROL)
                                                : $urandom_range(0, TABLE_SIZE - 1);
            count = $urandom_range(1, TABLE_SIZE - start);
            add_request(start, count, start + count);
         end else if (r < 88) begin
            start = $urandom_range(0, TABLE_SIZE - 1);
            count = $urandom_range(TABLE_SIZE + 1 - start, TABLE_SIZE + 4 - start);
            add_request(start, count, ($urandom_range(0, 4) == 0)
                        ? $urandom_range(TABLE_SIZE + 1, 131070) : start + count);
         end else begin
            add_noise_word();
         end
      end
   endtask

   task automatic run_phase(input hrwv_limits_type l, input bit req_idle, input bit rsp_idle);
      wait_idle();
      csr_write(CSR_SPEED_MIN, l.speed_min);
      csr_write(CSR_SPEED_MAX, l.speed_max);
      csr_write(CSR_PARITY_MIN, l.parity_min);
      csr_write(CSR_PARITY_MAX, l.parity_max);
      csr_write(CSR_ID_MIN, l.id_min);
      csr_write(CSR_ID_MAX, l.id_max);
      csr_write(CSR_CALIB_MIN, l.calib_min);
      csr_write(CSR_CALIB_MAX, l.calib_max);
      @(negedge clock);
      req_idle_on = req_idle;
      rsp_idle_on = rsp_idle;
      add_random_traffic(PHASE_WORDS);
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      settings = '0;
      limits   = default_limits();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // serial write while locked, then unlock and write both serial halves
      add_word(1'b1, 1'b1, ADDR_SERIAL_LO, 17'd9, 16'h1234);
      add_word(1'b1, 1'b1, ADDR_CONTROL, 17'd8, UNLOCK_MAGIC);
      add_word(1'b1, 1'b0, ADDR_SERIAL_LO, 17'd10, 16'hFFFF);
      add_word(1'b0, 1'b1, ADDR_SERIAL_HI, 17'd10, 16'h0000);
      // whole table in one request, every command pulse and one range edge per register accepted
      add_word(1'b1, 1'b0, ADDR_CLEAR, TABLE_END, CLEAR_MAGIC);
      add_word(1'b0, 1'b0, ADDR_SPEED, TABLE_END, 16'd7);
      add_word(1'b0, 1'b0, ADDR_PARITY, TABLE_END, 16'd2);
      add_word(1'b0, 1'b0, ADDR_ID, TABLE_END, 16'd247);
      add_word(1'b0, 1'b0, ADDR_TERM, TABLE_END, TERM_LOW);
      add_word(1'b0, 1'b0, ADDR_SAVE, TABLE_END, SAVE_MAGIC);
      add_word(1'b0, 1'b0, ADDR_RESTORE, TABLE_END, LOAD_MAGIC);
      add_word(1'b0, 1'b0, ADDR_CONTROL, TABLE_END, RESET_MAGIC);
      add_word(1'b0, 1'b0, ADDR_SERIAL_LO, TABLE_END, 16'h5A5A);
      add_word(1'b0, 1'b0, ADDR_SERIAL_HI, TABLE_END, 16'hA5A5);
      add_word(1'b0, 1'b0, ADDR_CALIB, TABLE_END, 16'h0000);
      add_word(1'b0, 1'b0, 16'd11, TABLE_END, 16'hFFFF);
      add_word(1'b0, 1'b1, 16'd12, TABLE_END, 16'h0000);
      // value errors stick for the rest of the request
      add_word(1'b1, 1'b0, ADDR_SPEED, 17'd4, 16'd8);
      add_word(1'b0, 1'b0, ADDR_PARITY, 17'd4, 16'd1);
      add_word(1'b0, 1'b1, ADDR_ID, 17'd4, 16'd0);
      // request past the table and address beyond the table
      add_word(1'b1, 1'b1, ADDR_CLEAR, TABLE_END + 17'd1, CLEAR_MAGIC);
      add_word(1'b1, 1'b1, 16'hFFFF, TABLE_END, SAVE_MAGIC);
      // bad termination, then a past-table word replaces the error, then lock
      add_word(1'b1, 1'b0, ADDR_TERM, 17'd5, 16'd3);
      add_word(1'b0, 1'b0, ADDR_SAVE, 17'd131070, 16'h0000);
      add_word(1'b0, 1'b1, ADDR_CONTROL, 17'd8, LOCK_MAGIC);

      run_phase(default_limits(), 1'b1, 1'b1);
      run_phase({4{16'h0000, 16'hFFFF}}, 1'b0, 1'b0);
      run_phase({4{16'hFFFF, 16'h0000}}, 1'b1, 1'b1);
      run_phase(random_limits(), 1'b1, 1'b0);
      run_phase(default_limits(), 1'b0, 1'b1);

      wait_idle();
      if (expected_outcomes.size() != 0)
         report_mismatch("results never arrived", expected_outcomes.size(), 0);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
